// ----- rtl/cdsa_pkg.sv -----
// Package for the central difference speed/acceleration core.
// Widths, sequencer state codes, inter-module structs and the 24-bit saturation.
// No dependencies.
package cdsa_pkg;

   localparam int TIME_W  = 32;
   localparam int NORM_W  = 16;
   localparam int SCALE_W = 17;
   localparam int RATE_W  = 16;
   localparam int POS_W   = 18;
   localparam int VEL_W   = 24;
   localparam int MAG_W   = 24;
   localparam int MUL_W   = 26;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SQ_W    = 47;
   localparam int RAD_W   = 48;
   localparam int CSR_W   = 17;
   localparam int IDX_W   = 2;

   localparam logic [IDX_W-1:0] CSR_PITCH_LENGTH = 2'd0;
   localparam logic [IDX_W-1:0] CSR_PITCH_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_INV_TWO_DT   = 2'd2;

   localparam logic [SCALE_W-1:0] PITCH_LENGTH_RST = 17'd105000;
   localparam logic [SCALE_W-1:0] PITCH_WIDTH_RST  = 17'd68000;
   localparam logic [RATE_W-1:0]  INV_TWO_DT_RST   = 16'd640;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_PX   = 16'h0002,
      ST_PY   = 16'h0004,
      ST_VX   = 16'h0008,
      ST_VY   = 16'h0010,
      ST_SX   = 16'h0020,
      ST_SY   = 16'h0040,
      ST_SUM  = 16'h0080,
      ST_WS   = 16'h0100,
      ST_AX   = 16'h0200,
      ST_AY   = 16'h0400,
      ST_QX   = 16'h0800,
      ST_QY   = 16'h1000,
      ST_ASUM = 16'h2000,
      ST_WA   = 16'h4000,
      ST_UPD  = 16'h8000
   } state_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sq_stat_type;

   // saturate a floor-shifted rate product to 24 bits signed
   function automatic logic signed [VEL_W-1:0] sat24(input logic signed [PROD_W-9:0] v);
      logic signed [VEL_W-1:0] r;
      if (v > $signed({{(PROD_W-8-VEL_W){1'b0}}, 1'b0, {(VEL_W-1){1'b1}}})) begin
         r = {1'b0, {(VEL_W-1){1'b1}}};
      end else if (v < $signed({{(PROD_W-8-VEL_W){1'b1}}, 1'b1, {(VEL_W-1){1'b0}}})) begin
         r = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         r = v[VEL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/cdsa_if.sv -----
// Valid/ready channel interfaces for sample requests and estimate responses.
// Depends on cdsa_pkg for field widths.
interface cdsa_req_if import cdsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_ms;
   logic [NORM_W-1:0] x_norm;
   logic [NORM_W-1:0] y_norm;

   modport source (output valid, time_ms, x_norm, y_norm, input ready);
   modport sink   (input valid, time_ms, x_norm, y_norm, output ready);
endinterface

interface cdsa_rsp_if import cdsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] speed_time_ms;
   logic [MAG_W-1:0]  speed_mm_s;
   logic              speed_valid;
   logic [TIME_W-1:0] accel_time_ms;
   logic [MAG_W-1:0]  accel_mm_s2;
   logic              accel_valid;
   logic [MAG_W-1:0]  max_speed_mm_s;

   modport source (output valid, speed_time_ms, speed_mm_s, speed_valid, accel_time_ms,
                   accel_mm_s2, accel_valid, max_speed_mm_s, input ready);
   modport sink   (input valid, speed_time_ms, speed_mm_s, speed_valid, accel_time_ms,
                   accel_mm_s2, accel_valid, max_speed_mm_s, output ready);
endinterface

// ----- rtl/cdsa_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on cdsa_pkg.
module cdsa_mul import cdsa_pkg::*; (
   input  logic                     clock,
   input  mul_req_type              req,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= req.a * req.b;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/cdsa_isqrt.sv -----
// Bit-serial floor square root, one result bit per cycle.
// Depends on cdsa_pkg.
module cdsa_isqrt import cdsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output sq_stat_type      stat,
   output logic [MAG_W-1:0] root
);

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(RAD_W-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = res_ff[MAG_W-1:0];

endmodule

// ----- rtl/central_difference_speed_accel_core.sv -----
// Central difference speed and acceleration estimator, top level.
// Depends on cdsa_pkg, cdsa_if, cdsa_mul and cdsa_isqrt.
//
// Before the third sample a transaction runs the position and x velocity steps and the
// update step. From the third sample on it adds the y velocity, both squares, the sum
// and the wait for the speed root, and from the fifth on the acceleration steps and the
// wait for its root. The core returns to idle after each update, and req.ready is
// high only while it is idle. The sequence is set by the single shared 26x26 multiplier
// and by the bit-serial square root. The multiplier produces one product per cycle for
// positions, rates and squares, each registered and ready in the next cycle, and each
// magnitude waits for the square root's done flag. A finished response sits in the
// output register until taken, and a new sample is accepted meanwhile. The core holds
// in its final step while the previous response is still waiting.
module central_difference_speed_accel_core import cdsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cdsa_req_if.sink         req,
   cdsa_rsp_if.source       rsp,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [SCALE_W-1:0] len_ff, wid_ff;
   logic [RATE_W-1:0]  inv_ff;

   logic [TIME_W-1:0]  t_ff;
   logic [NORM_W-1:0]  xn_ff, yn_ff;

   logic signed [POS_W-1:0] x_new_ff, y_new_ff;
   logic signed [POS_W-1:0] xh0_ff, xh1_ff, yh0_ff, yh1_ff;
   logic [TIME_W-1:0]       th0_ff, th1_ff;
   logic signed [VEL_W-1:0] vx_ff, vy_ff, ax_ff, ay_ff;
   logic signed [VEL_W-1:0] vxh0_ff, vxh1_ff, vyh0_ff, vyh1_ff;
   logic [SQ_W-1:0]         acc_ff;
   logic [MAG_W-1:0]        speed_ff, accel_ff, max_ff;
   logic [2:0]              count_ff;

   logic              rsp_valid_ff;
   logic [TIME_W-1:0] o_st_ff, o_at_ff;
   logic [MAG_W-1:0]  o_speed_ff, o_accel_ff, o_max_ff;
   logic              o_sv_ff, o_av_ff;

   mul_req_type              mreq;
   logic signed [PROD_W-1:0] prod;
   logic                     sq_start;
   logic [RAD_W-1:0]         sq_rad;
   sq_stat_type              sq_stat;
   logic [MAG_W-1:0]         sq_root;

   logic                     sv, av, accept, out_free;
   logic signed [POS_W-1:0]  pos_p;
   logic signed [VEL_W-1:0]  vel_p;
   logic [MAG_W-1:0]         max_new;

   cdsa_mul u_mul (
      .clock (clock),
      .req   (mreq),
      .prod  (prod)
   );

   cdsa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   assign sv       = count_ff >= 3'd2;
   assign av       = count_ff >= 3'd4;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pos_p    = prod[POS_W+15:16];
   assign vel_p    = sat24(prod[PROD_W-1:8]);
   assign sq_start = (state_ff == ST_SUM) || (state_ff == ST_ASUM);
   assign sq_rad   = {1'b0, acc_ff} + {1'b0, prod[SQ_W-1:0]};
   assign max_new  = (sv && speed_ff > max_ff) ? speed_ff : max_ff;

   // multiplier operand select
   always_comb begin
      mreq.a = '0;
      mreq.b = '0;
      unique case (state_ff)
         ST_PX: begin
            mreq.a = {{(MUL_W-NORM_W){~xn_ff[NORM_W-1]}}, ~xn_ff[NORM_W-1],
                      xn_ff[NORM_W-2:0]};
            mreq.b = {{(MUL_W-SCALE_W){1'b0}}, len_ff};
         end
         ST_PY: begin
            mreq.a = {{(MUL_W-NORM_W){~yn_ff[NORM_W-1]}}, ~yn_ff[NORM_W-1],
                      yn_ff[NORM_W-2:0]};
            mreq.b = {{(MUL_W-SCALE_W){1'b0}}, wid_ff};
         end
         ST_VX: begin
            mreq.a = {{(MUL_W-POS_W){x_new_ff[POS_W-1]}}, x_new_ff}
                   - {{(MUL_W-POS_W){xh1_ff[POS_W-1]}}, xh1_ff};
            mreq.b = {{(MUL_W-RATE_W){1'b0}}, inv_ff};
         end
         ST_VY: begin
            mreq.a = {{(MUL_W-POS_W){y_new_ff[POS_W-1]}}, y_new_ff}
                   - {{(MUL_W-POS_W){yh1_ff[POS_W-1]}}, yh1_ff};
            mreq.b = {{(MUL_W-RATE_W){1'b0}}, inv_ff};
         end
         ST_SX: begin
            mreq.a = {{(MUL_W-VEL_W){vx_ff[VEL_W-1]}}, vx_ff};
            mreq.b = mreq.a;
         end
         ST_SY: begin
            mreq.a = {{(MUL_W-VEL_W){vy_ff[VEL_W-1]}}, vy_ff};
            mreq.b = mreq.a;
         end
         ST_AX: begin
            mreq.a = {{(MUL_W-VEL_W){vx_ff[VEL_W-1]}}, vx_ff}
                   - {{(MUL_W-VEL_W){vxh1_ff[VEL_W-1]}}, vxh1_ff};
            mreq.b = {{(MUL_W-RATE_W){1'b0}}, inv_ff};
         end
         ST_AY: begin
            mreq.a = {{(MUL_W-VEL_W){vy_ff[VEL_W-1]}}, vy_ff}
                   - {{(MUL_W-VEL_W){vyh1_ff[VEL_W-1]}}, vyh1_ff};
            mreq.b = {{(MUL_W-RATE_W){1'b0}}, inv_ff};
         end
         ST_QX: begin
            mreq.a = {{(MUL_W-VEL_W){ax_ff[VEL_W-1]}}, ax_ff};
            mreq.b = mreq.a;
         end
         ST_QY: begin
            mreq.a = {{(MUL_W-VEL_W){ay_ff[VEL_W-1]}}, ay_ff};
            mreq.b = mreq.a;
         end
         default: begin
            mreq.a = '0;
            mreq.b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_PX;
         ST_PX:   state_in = ST_PY;
         ST_PY:   state_in = ST_VX;
         ST_VX:   state_in = sv ? ST_VY : ST_UPD;
         ST_VY:   state_in = ST_SX;
         ST_SX:   state_in = ST_SY;
         ST_SY:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_WS;
         ST_WS:   if (sq_stat.done) state_in = av ? ST_AX : ST_UPD;
         ST_AX:   state_in = ST_AY;
         ST_AY:   state_in = ST_QX;
         ST_QX:   state_in = ST_QY;
         ST_QY:   state_in = ST_ASUM;
         ST_ASUM: state_in = ST_WA;
         ST_WA:   if (sq_stat.done) state_in = ST_UPD;
         ST_UPD:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath captures
   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff  <= req.time_ms;
         xn_ff <= req.x_norm;
         yn_ff <= req.y_norm;
      end
      if (state_ff == ST_PY) x_new_ff <= pos_p;
      if (state_ff == ST_VX) y_new_ff <= pos_p;
      if (state_ff == ST_VY) vx_ff    <= vel_p;
      if (state_ff == ST_SX) vy_ff    <= vel_p;
      if (state_ff == ST_AY) ax_ff    <= vel_p;
      if (state_ff == ST_QX) ay_ff    <= vel_p;
      if (state_ff == ST_SY || state_ff == ST_QY) acc_ff <= prod[SQ_W-1:0];
      if (state_ff == ST_WS && sq_stat.done) speed_ff <= sq_root;
      if (state_ff == ST_WA && sq_stat.done) accel_ff <= sq_root;
      if (state_ff == ST_UPD && out_free) begin
         o_st_ff    <= sv ? th0_ff : '0;
         o_speed_ff <= sv ? speed_ff : '0;
         o_sv_ff    <= sv;
         o_at_ff    <= av ? th1_ff : '0;
         o_accel_ff <= av ? accel_ff : '0;
         o_av_ff    <= av;
         o_max_ff   <= max_new;
      end
   end

   // control, configuration and history state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= PITCH_LENGTH_RST;
         wid_ff       <= PITCH_WIDTH_RST;
         inv_ff       <= INV_TWO_DT_RST;
         xh0_ff       <= '0;
         xh1_ff       <= '0;
         yh0_ff       <= '0;
         yh1_ff       <= '0;
         th0_ff       <= '0;
         th1_ff       <= '0;
         vxh0_ff      <= '0;
         vxh1_ff      <= '0;
         vyh0_ff      <= '0;
         vyh1_ff      <= '0;
         count_ff     <= '0;
         max_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PITCH_LENGTH: len_ff <= csr_wdata;
               CSR_PITCH_WIDTH:  wid_ff <= csr_wdata;
               CSR_INV_TWO_DT:   inv_ff <= csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready && state_ff != ST_UPD) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_UPD && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (sv) begin
               vxh1_ff <= vxh0_ff;
               vyh1_ff <= vyh0_ff;
               vxh0_ff <= vx_ff;
               vyh0_ff <= vy_ff;
            end
            xh1_ff <= xh0_ff;
            yh1_ff <= yh0_ff;
            th1_ff <= th0_ff;
            xh0_ff <= x_new_ff;
            yh0_ff <= y_new_ff;
            th0_ff <= t_ff;
            max_ff <= max_new;
            if (count_ff < 3'd5) count_ff <= count_ff + 3'd1;
         end
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.speed_time_ms  = o_st_ff;
   assign rsp.speed_mm_s     = o_speed_ff;
   assign rsp.speed_valid    = o_sv_ff;
   assign rsp.accel_time_ms  = o_at_ff;
   assign rsp.accel_mm_s2    = o_accel_ff;
   assign rsp.accel_valid    = o_av_ff;
   assign rsp.max_speed_mm_s = o_max_ff;

   a_accept_to_px: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_PX)
      else $error("accepted transaction did not start the sequence");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd5)
      else $error("sample count above saturation");

   a_wait_has_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WS || state_ff == ST_WA) |-> (sq_stat.busy || sq_stat.done))
      else $error("waiting on square root that is not running");

   a_accel_needs_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!o_av_ff || o_sv_ff))
      else $error("acceleration flagged valid without speed");

   a_max_bounds_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_sv_ff) |-> (o_max_ff >= o_speed_ff))
      else $error("running maximum below reported speed");

endmodule
